// ===== rtl/n2a_pkg.sv =====
// Shared types, constants and helper functions of the number to ASCII formatter.
`default_nettype none
package n2a_pkg;

  // Format selector codes of a request.
  typedef enum logic [1:0] {
    ACT_DEC = 2'd0,
    ACT_HEX = 2'd1,
    ACT_CHR = 2'd2
  } act_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN,
    ST_X,
    ST_DIGIT,
    ST_EMIT,
    ST_LF,
    ST_CR,
    ST_CHAR
  } state_t;

  // ASCII constants.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Highest decimal and hex digit positions of a 16-bit value.
  localparam logic [2:0] DEC_TOP = 3'd4;
  localparam logic [2:0] HEX_TOP = 3'd3;

  // One character towards the output register.
  typedef struct packed {
    logic       vld;
    logic [7:0] chr;
    logic       last;
  } emit_t;

  // Power of ten for a decimal digit position.
  function automatic logic [13:0] pow10(input logic [2:0] k);
    logic [13:0] p;
    case (k)
      3'd0:    p = 14'd1;
      3'd1:    p = 14'd10;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd1000;
      3'd4:    p = 14'd10000;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

  // ASCII character of one hex or decimal digit, uppercase letters.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d <= 4'd9) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_UPA + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/n2a_cmpsub.sv =====
// Shared compare and subtract unit used for every decimal digit step.
`default_nettype none
module n2a_cmpsub
  import n2a_pkg::*;
(
  input  wire logic [15:0] rem,
  input  wire logic [16:0] sub,
  output logic             ge,
  output logic [15:0]      diff
);

  // The remainder is at least the subtrahend; the difference then fits 16 bits.
  assign ge   = ({1'b0, rem} >= sub);
  assign diff = rem - sub[15:0];

endmodule
`default_nettype wire

// ===== rtl/n2a_seq.sv =====
// Sequencer that walks the digits of one request and hands out characters.
`default_nettype none
module n2a_seq
  import n2a_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [1:0]  in_action,
  input  wire logic signed [15:0] in_value,
  input  wire logic               slot_free,
  output emit_t                   emit
);

  state_t      state_r, state_nxt;
  act_t        act_r, act_nxt;
  logic [15:0] mag_r, mag_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [1:0]  b_r, b_nxt;
  logic [3:0]  dig_r, dig_nxt;
  logic        started_r, started_nxt;

  logic [15:0] v_u;
  logic        accept;
  logic [16:0] sub;
  logic        ge;
  logic [15:0] diff;
  logic [3:0]  hex_dig;
  logic [3:0]  cur_dig;
  logic        show;

  assign v_u    = in_value;
  assign accept = in_valid && !in_stall;

  // Trial subtrahend: power of ten for this position, scaled by the bit under test.
  assign sub = {3'd0, pow10(k_r)} << b_r;

  n2a_cmpsub u_cmpsub (
    .rem  (mag_r),
    .sub  (sub),
    .ge   (ge),
    .diff (diff)
  );

  // Hex digits are plain nibbles of the held value.
  always_comb begin
    case (k_r[1:0])
      2'd0:    hex_dig = mag_r[3:0];
      2'd1:    hex_dig = mag_r[7:4];
      2'd2:    hex_dig = mag_r[11:8];
      2'd3:    hex_dig = mag_r[15:12];
      default: hex_dig = mag_r[3:0];
    endcase
  end

  assign cur_dig = (act_r == ACT_HEX) ? hex_dig : dig_r;
  // Leading zeros are dropped, but the units digit always shows.
  assign show    = (cur_dig != 4'd0) || started_r || (k_r == 3'd0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (act_t'(in_action))
            ACT_DEC: state_nxt = v_u[15] ? ST_SIGN : ST_DIGIT;
            ACT_HEX: state_nxt = ST_SIGN;
            ACT_CHR: state_nxt = ST_CHAR;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          state_nxt = (act_r == ACT_HEX) ? ST_X : ST_DIGIT;
        end
      end
      ST_X: begin
        if (slot_free) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DIGIT: begin
        if (b_r == 2'd0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!show || slot_free) begin
          if (k_r == 3'd0) begin
            state_nxt = (act_r == ACT_HEX) ? ST_IDLE : ST_LF;
          end else begin
            state_nxt = (act_r == ACT_HEX) ? ST_EMIT : ST_DIGIT;
          end
        end
      end
      ST_LF: begin
        if (slot_free) begin
          state_nxt = ST_CR;
        end
      end
      ST_CR, ST_CHAR: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and character outputs.
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    emit.vld  = 1'b0;
    emit.chr  = CH_ZERO;
    emit.last = 1'b0;
    case (state_r)
      ST_SIGN: begin
        emit.vld = slot_free;
        emit.chr = (act_r == ACT_HEX) ? CH_ZERO : CH_MINUS;
      end
      ST_X: begin
        emit.vld = slot_free;
        emit.chr = CH_X;
      end
      ST_EMIT: begin
        emit.vld  = slot_free && show;
        emit.chr  = digit_char(cur_dig);
        emit.last = (act_r == ACT_HEX) && (k_r == 3'd0);
      end
      ST_LF: begin
        emit.vld = slot_free;
        emit.chr = CH_LF;
      end
      ST_CR: begin
        emit.vld  = slot_free;
        emit.chr  = CH_CR;
        emit.last = 1'b1;
      end
      ST_CHAR: begin
        emit.vld  = slot_free;
        emit.chr  = mag_r[7:0];
        emit.last = 1'b1;
      end
      default: begin
        emit.vld = 1'b0;
      end
    endcase
  end

  // Datapath registers: magnitude, digit position, bit step and digit.
  always_comb begin
    act_nxt     = act_r;
    mag_nxt     = mag_r;
    k_nxt       = k_r;
    b_nxt       = b_r;
    dig_nxt     = dig_r;
    started_nxt = started_r;
    if (state_r == ST_IDLE) begin
      if (accept) begin
        act_nxt     = act_t'(in_action);
        started_nxt = 1'b0;
        b_nxt       = 2'd3;
        dig_nxt     = 4'd0;
        if (act_t'(in_action) == ACT_DEC) begin
          // Two's complement magnitude; the most negative value gives 0x8000.
          mag_nxt = v_u[15] ? (16'd0 - v_u) : v_u;
          k_nxt   = DEC_TOP;
        end else begin
          mag_nxt = v_u;
          k_nxt   = HEX_TOP;
        end
      end
    end else if (state_r == ST_DIGIT) begin
      if (ge) begin
        mag_nxt         = diff;
        dig_nxt[b_r]    = 1'b1;
      end
      b_nxt = b_r - 2'd1;
    end else if (state_r == ST_EMIT) begin
      if (!show || slot_free) begin
        started_nxt = started_r || show;
        dig_nxt     = 4'd0;
        b_nxt       = 2'd3;
        if (k_r != 3'd0) begin
          k_nxt = k_r - 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    mag_r     <= mag_nxt;
    k_r       <= k_nxt;
    b_r       <= b_nxt;
    dig_r     <= dig_nxt;
    started_r <= started_nxt;
  end

`ifndef NO_ASSERTIONS
  // A meaningful request always starts a run.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action != 2'd3) |=> (state_r != ST_IDLE))
    else $error("request with a valid format left the sequencer idle");

  // Only decimal requests use the shared subtract unit.
  a_digit_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIGIT) |-> (act_r == ACT_DEC))
    else $error("digit step entered outside decimal mode");

  // The remainder is below ten times the weight of the digit being found.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIGIT && b_r == 2'd3) |->
      ({4'd0, mag_r} < ({6'd0, pow10(k_r)} * 20'd10)))
    else $error("remainder too large for the digit position");

  // A finished digit is always a decimal digit.
  a_digit_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && act_r == ACT_DEC) |-> (dig_r <= 4'd9))
    else $error("decimal digit above nine");
`endif

endmodule
`default_nettype wire

// ===== rtl/number_to_ascii_formatter.sv =====
// Top level of the number to ASCII formatter with its output register.
//
//   channel  direction  ports
//   in_      request    in_valid, in_stall, in_action, in_value
//   out_     result     out_valid, out_stall, out_text_byte, out_last
//
// One request is taken at a time; in_stall stays high until its last
// character has entered the output register. A decimal digit is found by
// one trial subtraction per bit in the shared compare and subtract unit,
// then handed out. Stalls on the output hold the sequencer in any state
// that has a character to hand out; digit steps do not wait for them.
// Reset (rst_n low at a clock edge) empties the output and idles the sequencer.
`default_nettype none
module number_to_ascii_formatter
  import n2a_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [1:0]  in_action,
  input  wire logic signed [15:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [7:0]  out_text_byte,
  output logic                    out_last
);

  logic       out_vld_r, out_vld_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       slot_free;
  emit_t      emit;

  // The register can take a character when empty or being drained.
  assign slot_free = !out_vld_r || !out_stall;

  n2a_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .in_value  (in_value),
    .slot_free (slot_free),
    .emit      (emit)
  );

  // Output register loading.
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    if (emit.vld) begin
      out_vld_nxt  = 1'b1;
      out_byte_nxt = emit.chr;
      out_last_nxt = emit.last;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_text_byte = out_byte_r;
  assign out_last      = out_last_r;

endmodule
`default_nettype wire
